### src/lsa_pkg.sv
// Package for the linear-scan slot allocator: field widths and the
// transaction payload structs shared by the core and its testbench.
// No dependencies.
package lsa_pkg;

  localparam int ID_W   = 16;
  localparam int POS_W  = 16;
  localparam int ASLOT_W = 3;

  typedef struct packed {
    logic [ID_W-1:0]  interval_id;
    logic [POS_W-1:0] def_position;
    logic [POS_W-1:0] last_use_position;
  } item_t;

  typedef struct packed {
    logic [ASLOT_W-1:0] assigned_slot;
    logic               spill_flag;
    logic [ID_W-1:0]    victim_id;
  } result_t;

endpackage

### src/linear_scan_slot_allocator_core.sv
// Linear-scan slot allocator core: sequencer, scan compare unit and
// occupancy bits. Depends on lsa_pkg and lsa_slot_mem.
//
// Each accepted interval walks the NUM_SLOTS-1 allocatable slots in order,
// one slot per cycle, through a single compare unit fed by the slot memory's
// registered read port. The walk stops at the first free slot (empty, or its
// occupant's last use at or before the new definition). While walking it
// also keeps the slot with the furthest last use (lowest index on a tie), so
// when no slot is free the spill decision is ready at the end of the same
// pass. From acceptance an item walks the slots in S_SCAN, slot 0 being
// fetched while idle, up to the stopping slot (a full table walks them all),
// then its decision is committed to the result register in S_FIN, and
// the next item can be taken in the cycle after the commit. The input is
// not ready during the walk; the result register lets a new item be taken
// while the previous result still waits. assigned_slot reports the low
// three bits of the slot number; victim_id is zero when nothing is spilled.
// The occupancy bits clear at reset; no clearing pass is needed.
module linear_scan_slot_allocator_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  lsa_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output lsa_pkg::result_t result
);

  localparam int DEPTH  = NUM_SLOTS - 1;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] RESERVED = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  // latched transaction and scan bookkeeping
  lsa_pkg::item_t cur;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] best_idx;
  logic [lsa_pkg::POS_W-1:0] best_last;
  logic [lsa_pkg::ID_W-1:0]  best_owner;
  logic [DEPTH-1:0] occupied;

  // pending decision, committed in S_FIN
  logic [SLOT_W-1:0]        res_slot;
  logic                     res_spill;
  logic [lsa_pkg::ID_W-1:0] res_victim;
  logic                     res_wr;
  logic [IDX_W-1:0]         res_idx;

  // memory ports
  logic [IDX_W-1:0]          rd_addr;
  logic [lsa_pkg::ID_W-1:0]  rd_owner;
  logic [lsa_pkg::POS_W-1:0] rd_last;
  logic                      wr_en;

  logic accept, commit, slot_free, take, scan_done;
  logic [lsa_pkg::POS_W-1:0] cand_last;
  logic [lsa_pkg::ID_W-1:0]  cand_owner;
  logic [IDX_W-1:0]          cand_idx;

  lsa_slot_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (res_idx),
    .wr_owner (cur.interval_id),
    .wr_last  (cur.last_use_position),
    .rd_addr  (rd_addr),
    .rd_owner (rd_owner),
    .rd_last  (rd_last)
  );

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  // commit the decision once the result register is free
  assign commit     = (state == S_FIN) && (!result_valid || result_ready);
  assign wr_en      = commit && res_wr;

  // Prefetch slot 0 while idle; during the walk fetch the next slot.
  always_comb begin
    if (state == S_SCAN && idx != LAST_IDX) begin
      rd_addr = idx + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  // shared compare unit: free test and furthest-last-use tracking
  assign slot_free  = !occupied[idx] || (rd_last <= cur.def_position);
  assign take       = (idx == '0) || (best_last < rd_last);
  assign cand_last  = take ? rd_last  : best_last;
  assign cand_owner = take ? rd_owner : best_owner;
  assign cand_idx   = take ? idx      : best_idx;
  assign scan_done  = slot_free || (idx == LAST_IDX);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      occupied     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (wr_en) begin
        occupied[res_idx] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
      idx <= '0;
    end
    if (state == S_SCAN) begin
      best_idx   <= cand_idx;
      best_last  <= cand_last;
      best_owner <= cand_owner;
      if (!scan_done) begin
        idx <= idx + IDX_W'(1);
      end else if (slot_free) begin
        res_slot   <= SLOT_W'(idx);
        res_spill  <= 1'b0;
        res_victim <= '0;
        res_wr     <= 1'b1;
        res_idx    <= idx;
      end else if (cand_last < cur.last_use_position) begin
        // arriving interval is furthest: spill it, leave the table alone
        res_slot   <= RESERVED;
        res_spill  <= 1'b1;
        res_victim <= cur.interval_id;
        res_wr     <= 1'b0;
        res_idx    <= cand_idx;
      end else begin
        res_slot   <= SLOT_W'(cand_idx);
        res_spill  <= 1'b1;
        res_victim <= cand_owner;
        res_wr     <= 1'b1;
        res_idx    <= cand_idx;
      end
    end
    if (commit) begin
      result.assigned_slot <= lsa_pkg::ASLOT_W'(res_slot);
      result.spill_flag    <= res_spill;
      result.victim_id     <= res_victim;
    end
  end

`ifndef SYNTH
  // a busy walk must drop ready right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item_ready still high after acceptance");

  // a result without a spill carries no victim
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.spill_flag) |-> (result.victim_id == '0))
    else $error("victim_id nonzero without spill");

  // the walk never runs past the last allocatable slot
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx <= LAST_IDX))
    else $error("scan index out of range");

  // a table write leaves its slot marked occupied
  a_occ_set: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> occupied[$past(res_idx)])
    else $error("written slot not marked occupied");
`endif

endmodule

### src/lsa_slot_mem.sv
// Slot table storage: occupant id and last-use position per slot.
// One write port, one read port with registered read data.
// Depends on lsa_pkg for field widths.
module lsa_slot_mem #(
  parameter int DEPTH = 7,
  parameter int IDX_W = 3
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [lsa_pkg::ID_W-1:0]    wr_owner,
  input  logic [lsa_pkg::POS_W-1:0]   wr_last,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [lsa_pkg::ID_W-1:0]    rd_owner,
  output logic [lsa_pkg::POS_W-1:0]   rd_last
);

  logic [lsa_pkg::ID_W-1:0]  owner_mem [DEPTH];
  logic [lsa_pkg::POS_W-1:0] last_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_owner;
      last_mem[wr_addr]  <= wr_last;
    end
    rd_owner <= owner_mem[rd_addr];
    rd_last  <= last_mem[rd_addr];
  end

endmodule

### bench/linear_scan_slot_allocator_core_test.sv
// Self-checking bench for linear_scan_slot_allocator_core: drives intervals,
// tracks the slot table on the side and checks every allocation result.
// Depends on lsa_pkg and the core under src/.
`timescale 1ns / 1ps

module linear_scan_slot_allocator_core_test;

  localparam int SLOTS       = 8;
  localparam int TAIL_CYCLES = 2 * (SLOTS + 1) + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 100;

  // Side copy of the allocation table. Noting an interval works out the
  // slot it gets (or the spill) and queues that outcome; each result from
  // the core is checked against the oldest queued outcome.
  class slot_allocation_tracker;
    bit                        busy[SLOTS-1];
    logic [lsa_pkg::ID_W-1:0]  owner[SLOTS-1];
    logic [lsa_pkg::POS_W-1:0] last_use[SLOTS-1];
    lsa_pkg::result_t          pending_allocations[$];
    int                        failures;

    function void note_interval(lsa_pkg::item_t it);
      lsa_pkg::result_t          r;
      int                        k;
      int                        best;
      logic [lsa_pkg::POS_W-1:0] best_last;
      bit                        placed;
      r = '0;
      placed = 0;
      for (k = 0; k < SLOTS - 1 && !placed; k++) begin
        if (!busy[k] || last_use[k] <= it.def_position) begin
          busy[k] = 1'b1;
          owner[k] = it.interval_id;
          last_use[k] = it.last_use_position;
          r.assigned_slot = lsa_pkg::ASLOT_W'(k);
          placed = 1;
        end
      end
      if (!placed) begin
        best = 0;
        best_last = last_use[0];
        for (k = 1; k < SLOTS - 1; k++) begin
          if (best_last < last_use[k]) begin
            best = k;
            best_last = last_use[k];
          end
        end
        r.spill_flag = 1'b1;
        if (best_last < it.last_use_position) begin
          r.assigned_slot = lsa_pkg::ASLOT_W'(SLOTS - 1);
          r.victim_id = it.interval_id;
        end else begin
          r.assigned_slot = lsa_pkg::ASLOT_W'(best);
          r.victim_id = owner[best];
          owner[best] = it.interval_id;
          last_use[best] = it.last_use_position;
        end
      end
      pending_allocations.push_back(r);
    endfunction

    function void check_result(lsa_pkg::result_t got);
      lsa_pkg::result_t want;
      if (pending_allocations.size() == 0) begin
        $error("result with no interval outstanding: slot %0d spill %0d victim %0h",
               got.assigned_slot, got.spill_flag, got.victim_id);
        failures++;
        return;
      end
      want = pending_allocations.pop_front();
      if (got.assigned_slot !== want.assigned_slot) begin
        $error("assigned_slot: expected %0d, got %0d", want.assigned_slot,
               got.assigned_slot);
        failures++;
      end
      if (got.spill_flag !== want.spill_flag) begin
        $error("spill_flag: expected %0d, got %0d", want.spill_flag, got.spill_flag);
        failures++;
      end
      if (got.victim_id !== want.victim_id) begin
        $error("victim_id: expected %0h, got %0h", want.victim_id, got.victim_id);
        failures++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  lsa_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  lsa_pkg::result_t result;

  slot_allocation_tracker tracker = new;

  // Idle control shared by both sides; the long hold is requested by the
  // sender and carried out by the receiver.
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  linear_scan_slot_allocator_core #(.NUM_SLOTS(SLOTS)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Watch both channels. Signals read here are the values before this edge,
  // since everything is driven with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) tracker.note_interval(item);
      if (result_valid && result_ready) tracker.check_result(result);
    end
  end

  // Offer one interval: optionally drop valid for an idle burst first, then
  // hold valid and payload until the transaction goes through. Valid is left
  // high afterwards so back-to-back transactions need no extra assignment.
  task automatic send_interval(lsa_pkg::item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  function automatic lsa_pkg::item_t make_item(logic [15:0] id, logic [15:0] def,
                                               logic [15:0] last);
    lsa_pkg::item_t it;
    it.interval_id = id;
    it.def_position = def;
    it.last_use_position = last;
    return it;
  endfunction

  // Receiver: ready most of the time, with random idle bursts, plus one long
  // hold-off so the core fills up and stalls its input.
  initial begin
    int hold_count;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        hold_count = 0;
        while (hold_count < LONG_HOLD) begin
          @(posedge clk);
          hold_count++;
        end
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed intervals, random phases, drain.
  initial begin
    lsa_pkg::item_t            it;
    logic [lsa_pkg::POS_W-1:0] cursor;
    int                        step_max;
    int                        span_max;
    int                        p;
    int                        n;
    int                        pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, zero fields, then last use before definition.
    send_interval(make_item(16'h0000, 16'h0000, 16'h0000));
    send_interval(make_item(16'hFFFF, 16'h0001, 16'h0000));
    // Fill all allocatable slots with long intervals, two sharing a last use.
    send_interval(make_item(16'h0101, 16'h0002, 16'h1000));
    send_interval(make_item(16'h0202, 16'h0002, 16'h3000));
    send_interval(make_item(16'h0303, 16'h0002, 16'h3000));
    send_interval(make_item(16'h0404, 16'h0002, 16'h2000));
    send_interval(make_item(16'h0505, 16'h0002, 16'h0800));
    send_interval(make_item(16'h0606, 16'h0002, 16'h1800));
    send_interval(make_item(16'h0707, 16'h0002, 16'h0900));
    // Full table: arriving interval lasts longest and spills itself.
    send_interval(make_item(16'hA5A5, 16'h0003, 16'h4000));
    // Tie with the furthest occupant: the occupant at the lower slot goes.
    send_interval(make_item(16'h5A5A, 16'h0003, 16'h3000));
    // Short arriving interval still evicts the furthest occupant.
    send_interval(make_item(16'h1234, 16'h0004, 16'h0001));
    // Definitions past occupants' last uses take the first slot so freed.
    send_interval(make_item(16'h4321, 16'h0800, 16'h0C00));
    send_interval(make_item(16'h8000, 16'h0900, 16'h7FFF));
    // Top of the position range frees everything.
    send_interval(make_item(16'h7FFF, 16'hFFFF, 16'hFFFF));
    send_interval(make_item(16'hFFFE, 16'hFFFF, 16'hFFFF));
    // Maximal last uses from position zero find no free slot and spill on ties.
    for (n = 0; n < SLOTS - 1; n++) begin
      send_interval(make_item(lsa_pkg::ID_W'(16'hC000 + n), 16'h0000, 16'hFFFF));
    end
    send_interval(make_item(16'hDEAD, 16'h0000, 16'hFFFF));
    send_interval(make_item(16'hBEEF, 16'h0000, 16'h0000));

    // Random phases: mostly intervals in definition order with random spans,
    // sized so some phases keep slots free and others force spills. The rest
    // is noise and intervals that end before they begin.
    for (p = 0; p < PHASES; p++) begin
      idle_on = (p != 4) && (p != 7) && (p < PHASES - 1);
      cursor = lsa_pkg::POS_W'($urandom);
      case ($urandom_range(0, 2))
        0: step_max = 1;
        1: step_max = 4;
        default: step_max = 16;
      endcase
      case ($urandom_range(0, 3))
        0: span_max = 8;
        1: span_max = 64;
        2: span_max = 512;
        default: span_max = 4096;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Ask the receiver for its long hold once, early on.
        if (p == 2 && n == 30) hold_request = 1'b1;
        pick = $urandom_range(0, 19);
        it.interval_id = lsa_pkg::ID_W'($urandom);
        if (pick < 2) begin
          it.def_position = lsa_pkg::POS_W'($urandom);
          it.last_use_position = lsa_pkg::POS_W'($urandom);
        end else begin
          cursor = lsa_pkg::POS_W'(cursor + $urandom_range(0, step_max));
          it.def_position = cursor;
          if (pick == 2) begin
            it.last_use_position = lsa_pkg::POS_W'(cursor - $urandom_range(1, 500));
          end else begin
            it.last_use_position = lsa_pkg::POS_W'(cursor + $urandom_range(0, span_max));
          end
        end
        send_interval(it);
      end
    end

    // Drop valid, then wait for every outstanding allocation and a tail.
    item_valid <= 1'b0;
    while (tracker.pending_allocations.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending_allocations.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
